FILE: hw/rtl/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// shared constants, pipeline word type and the shift-add-3 step for the
// signed binary to decimal ascii converter
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int DATA_WIDTH      = 16;
  localparam int MAX_DIGITS      = 5;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = (DATA_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int SHIFT_W         = NUM_STAGES * STEPS_PER_STAGE;
  localparam int BCD_W           = 4 * MAX_DIGITS;
  localparam int DIGIT_IDX_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W           = $clog2(MAX_DIGITS + 1);
  localparam int CHAR_W          = 7;
  localparam int LEN_W           = 3;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

  // word carried down the conversion pipeline
  typedef struct packed {
    logic               neg;  // value was negative
    logic               ovf;  // a digit carried out of the top bcd digit
    logic [BCD_W-1:0]   bcd;  // packed decimal digits, least significant low
    logic [SHIFT_W-1:0] bin;  // binary bits still to shift in, msb first
  } work_t;

  // one shift-add-3 step: correct every digit, then shift one binary bit in
  function automatic work_t dabble_step(work_t w);
    work_t      r;
    logic [3:0] d;
    r = w;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      d = r.bcd[4*i +: 4];
      if (d >= 4'd5) begin
        r.bcd[4*i +: 4] = d + 4'd3;
      end
    end
    r.ovf = w.ovf | r.bcd[BCD_W-1];
    {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
    return r;
  endfunction

endpackage

FILE: hw/rtl/sbda_sign_stage.sv
// ----------------------------------------------------------------------------
// sbda_sign_stage
// first pipeline stage: splits the input into sign and magnitude
// ----------------------------------------------------------------------------
module sbda_sign_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sbda_pkg::DATA_WIDTH-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sbda_pkg::work_t                   out_work
);

  logic                              neg;
  logic [sbda_pkg::DATA_WIDTH-1:0]   mag;
  sbda_pkg::work_t                   work_next;

  // two's complement negation also gives the right magnitude for the most
  // negative value when read as unsigned
  always_comb begin
    neg             = value[sbda_pkg::DATA_WIDTH-1];
    mag             = neg ? (~value + sbda_pkg::DATA_WIDTH'(1)) : value;
    work_next.neg   = neg;
    work_next.ovf   = 1'b0;
    work_next.bcd   = '0;
    work_next.bin   = sbda_pkg::SHIFT_W'(mag);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule

FILE: hw/rtl/sbda_dabble_stage.sv
// ----------------------------------------------------------------------------
// sbda_dabble_stage
// one pipeline stage of the binary to bcd conversion, a few bit steps each
// ----------------------------------------------------------------------------
module sbda_dabble_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sbda_pkg::work_t in_work,
  output logic            out_valid,
  input  logic            out_ready,
  output sbda_pkg::work_t out_work
);

  sbda_pkg::work_t work_next;

  always_comb begin
    work_next = in_work;
    for (int s = 0; s < sbda_pkg::STEPS_PER_STAGE; s++) begin
      work_next = sbda_pkg::dabble_step(work_next);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule

FILE: hw/rtl/sbda_serializer.sv
// ----------------------------------------------------------------------------
// sbda_serializer
// holds one converted value and sends its characters one transfer at a time
// ----------------------------------------------------------------------------
module sbda_serializer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sbda_pkg::work_t                in_work,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sbda_pkg::CHAR_W-1:0]    character,
  output logic                           last,
  output logic [sbda_pkg::LEN_W-1:0]     length
);

  logic [3:0]                      digits [sbda_pkg::MAX_DIGITS];
  logic                            busy;
  logic                            minus_pending;
  logic [sbda_pkg::DIGIT_IDX_W-1:0] idx;
  logic [sbda_pkg::LEN_W-1:0]      total;

  logic                            out_adv;
  logic                            finishing;
  logic                            load;
  logic [sbda_pkg::CNT_W-1:0]      cnt;
  logic [3:0]                      cur_digit;

  // digit count: highest nonzero digit, at least one, all of them on overflow
  always_comb begin
    cnt = sbda_pkg::CNT_W'(1);
    for (int i = 0; i < sbda_pkg::MAX_DIGITS; i++) begin
      if (in_work.bcd[4*i +: 4] != 4'd0) begin
        cnt = sbda_pkg::CNT_W'(i + 1);
      end
    end
    if (in_work.ovf) begin
      cnt = sbda_pkg::CNT_W'(sbda_pkg::MAX_DIGITS);
    end
  end

  assign cur_digit = digits[idx];
  assign out_adv   = !out_valid || !out_stall;
  assign finishing = busy && out_adv && !minus_pending && (idx == '0);
  assign in_ready  = !busy || finishing;
  assign load      = in_ready && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      minus_pending <= 1'b0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid <= busy;
        if (busy) begin
          if (minus_pending) begin
            minus_pending <= 1'b0;
          end else if (idx != '0) begin
            idx <= idx - sbda_pkg::DIGIT_IDX_W'(1);
          end
        end
      end
      // a new item may load on the cycle the previous one sends its last digit
      if (load) begin
        busy          <= 1'b1;
        minus_pending <= in_work.neg;
        idx           <= sbda_pkg::DIGIT_IDX_W'(cnt - sbda_pkg::CNT_W'(1));
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < sbda_pkg::MAX_DIGITS; i++) begin
        digits[i] <= in_work.bcd[4*i +: 4];
      end
      total <= sbda_pkg::LEN_W'(cnt + sbda_pkg::CNT_W'(in_work.neg));
    end
    if (out_adv && busy) begin
      if (minus_pending) begin
        character <= sbda_pkg::ASCII_MINUS;
        last      <= 1'b0;
        length    <= '0;
      end else begin
        character <= sbda_pkg::ASCII_ZERO + sbda_pkg::CHAR_W'(cur_digit);
        last      <= (idx == '0);
        length    <= (idx == '0) ? total : '0;
      end
    end
  end

  a_len_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> length != '0)
    else $error("length is zero on last character");

  a_len_zero_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> length == '0)
    else $error("length nonzero before last character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && character == sbda_pkg::ASCII_MINUS |-> !last)
    else $error("minus sign marked last");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    load |=> busy)
    else $error("loaded item not held");

endmodule

FILE: hw/rtl/signed_binary_to_decimal_ascii_core.sv
// path: sign stage, four shift-add-3 stages, serializer load, output register
// throughput: one character per cycle unless out_stall; an item is 1 to 6
//   characters (digits plus minus sign); the pipeline accepts every cycle
//   unless in_stall is high
// reset: synchronous active-high rst clears all valid and control state
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core
// converts a signed integer into its decimal ascii text, one character per
// output transfer, with last flag and run length on the final character
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [sbda_pkg::DATA_WIDTH-1:0] value,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [sbda_pkg::CHAR_W-1:0]            character,
  output logic                                   last,
  output logic [sbda_pkg::LEN_W-1:0]             length
);

  // handshake and data between pipeline stages; entry 0 is the sign stage
  // output, entry k the output of shift-add-3 stage k-1
  logic            stg_valid [sbda_pkg::NUM_STAGES+1];
  logic            stg_ready [sbda_pkg::NUM_STAGES+1];
  sbda_pkg::work_t stg_work  [sbda_pkg::NUM_STAGES+1];

  logic            in_ready;

  // stall is just the inverse of the first stage's ready
  assign in_stall = !in_ready;

  // sign and magnitude split
  sbda_sign_stage u_sign (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_work  (stg_work[0])
  );

  // binary to bcd, a fixed number of bit steps per stage
  for (genvar g = 0; g < sbda_pkg::NUM_STAGES; g++) begin : g_dabble
    sbda_dabble_stage u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_work   (stg_work[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_work  (stg_work[g+1])
    );
  end

  // character sequencer with registered output, one transfer per character
  sbda_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[sbda_pkg::NUM_STAGES]),
    .in_ready  (stg_ready[sbda_pkg::NUM_STAGES]),
    .in_work   (stg_work[sbda_pkg::NUM_STAGES]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last),
    .length    (length)
  );

endmodule
